// ----- design/quadrature_detent_accel_decoder_defines.svh -----
// Assertion macros shared by the decoder modules.
`ifndef QUADRATURE_DETENT_ACCEL_DECODER_DEFINES_SVH
`define QUADRATURE_DETENT_ACCEL_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define QDAD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define QDAD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/qdad_pkg.sv -----
// Types, constants and lookup functions of the quadrature detent decoder.
package qdad_pkg;

    localparam int POS_W  = 32;
    localparam int RATE_W = 16;

    // Configuration register indexes.
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_DETENT_MODE     = 3'd0;
    localparam reg_idx_t REG_RANGE_MIN       = 3'd1;
    localparam reg_idx_t REG_RANGE_MAX       = 3'd2;
    localparam reg_idx_t REG_RATE_FLOOR      = 3'd3;
    localparam reg_idx_t REG_RATE_CEILING    = 3'd4;
    localparam reg_idx_t REG_FULL_SPAN_TICKS = 3'd5;

    localparam logic [2:0] ENC_TYPE_MAX = 3'd4;

    typedef struct packed {
        logic [2:0]              detent_mode;
        logic signed [POS_W-1:0] range_min;
        logic signed [POS_W-1:0] range_max;
        logic [RATE_W-1:0]       rate_floor;
        logic [RATE_W-1:0]       rate_ceiling;
        logic [RATE_W-1:0]       full_span_ticks;
    } cfg_t;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_MOVE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        dir_t                    dir;
        logic                    hit;
        logic [RATE_W-1:0]       rate;
        logic signed [POS_W-1:0] new_position;
    } cmd_t;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Acceleration unit widths.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int CUBE_W  = 3 * RATE_W;
    localparam int NUM_W   = POS_W + CUBE_W;
    localparam int DIV_CNT_W = $clog2(POS_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(POS_W - 1);

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] rate;
    } acc_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] step;
    } acc_rsp_t;

    typedef enum logic [3:0] {
        ACC_IDLE,
        ACC_DIV_SPAN,
        ACC_MUL_SS,
        ACC_MUL_C,
        ACC_MUL_DD,
        ACC_MUL_D3,
        ACC_MUL_PLO,
        ACC_MUL_PHI,
        ACC_SUM,
        ACC_DIV_Q,
        ACC_DONE
    } acc_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ACCEL,
        BK_APPLY
    } bk_state_t;

    // Direction of a pin-state change, indexed by old and new state.
    function automatic dir_t dir_lookup(input logic [1:0] prev, input logic [1:0] now);
        dir_t d;
        unique case ({prev, now})
            4'd2, 4'd4, 4'd11, 4'd13: d = DIR_UP;
            4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_DOWN;
            default:                  d = DIR_NONE;
        endcase
        return d;
    endfunction

    // Bit k set: pin state k is a detent for this encoder type.
    function automatic logic [3:0] detent_mask(input logic [2:0] enc_type);
        logic [3:0] m;
        unique case (enc_type)
            3'd0:    m = 4'h8;
            3'd1:    m = 4'h1;
            3'd2:    m = 4'h9;
            3'd3:    m = 4'h6;
            3'd4:    m = 4'hF;
            default: m = 4'h8;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] detent_shift(input logic [2:0] enc_type);
        logic [1:0] s;
        unique case (enc_type)
            3'd0, 3'd1: s = 2'd2;
            3'd2, 3'd3: s = 2'd1;
            3'd4:       s = 2'd0;
            default:    s = 2'd2;
        endcase
        return s;
    endfunction

endpackage

// ----- design/qdad_front.sv -----
// Input side: tracks the pin state and classifies each item into a command.
module qdad_front
    import qdad_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_func,
    input  logic                    s_pin_a,
    input  logic                    s_pin_b,
    input  logic [RATE_W-1:0]       s_detent_rate,
    input  logic signed [POS_W-1:0] s_new_position,
    input  logic                    q_full,
    output logic                    q_push,
    output cmd_t                    q_data
);

    logic [1:0] prev_pins_reg;
    logic [1:0] prev_pins_next;
    logic [1:0] now_pins;
    logic [3:0] mask;

    assign now_pins = {s_pin_b, s_pin_a};
    assign mask     = detent_mask(cfg.detent_mode);
    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;

    always_comb begin
        q_data.rate         = s_detent_rate;
        q_data.new_position = s_new_position;
        q_data.dir          = DIR_NONE;
        q_data.hit          = 1'b0;
        prev_pins_next      = prev_pins_reg;
        if (s_func) begin
            q_data.kind = CMD_LOAD;
        end else if (now_pins == prev_pins_reg) begin
            q_data.kind = CMD_HOLD;
        end else begin
            q_data.kind    = CMD_MOVE;
            q_data.dir     = dir_lookup(prev_pins_reg, now_pins);
            q_data.hit     = mask[now_pins];
            prev_pins_next = now_pins;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pins_reg <= 2'b00;
        end else if (q_push) begin
            prev_pins_reg <= prev_pins_next;
        end
    end

endmodule

// ----- design/qdad_fifo.sv -----
// Short command queue between the front and back parts.
module qdad_fifo
    import qdad_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output cmd_t rdata,
    output logic empty
);

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/qdad_accel.sv -----
// Acceleration step unit: one shared multiplier and a shared restoring divider.
module qdad_accel
    import qdad_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  acc_req_t req,
    output acc_rsp_t rsp
);

`include "quadrature_detent_accel_decoder_defines.svh"

    acc_state_t state_reg;
    acc_state_t state_next;

    logic [RATE_W-1:0]    s_reg;
    logic [RATE_W-1:0]    d_reg;
    logic [POS_W-1:0]     dl_reg;
    logic [CUBE_W-1:0]    cube_reg;
    logic [CUBE_W-1:0]    div_reg;
    logic [CUBE_W-1:0]    rem_reg;
    logic [POS_W-1:0]     qd_reg;
    logic [MUL_P_W-1:0]   mul_reg;
    logic [MUL_P_W-1:0]   plo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [RATE_W-1:0]  rate_clamped;
    logic [RATE_W-1:0]  s_val;
    logic [RATE_W-1:0]  d_val;
    logic               trivial;
    logic [POS_W:0]     span;
    logic               span_pos;
    logic [RATE_W-1:0]  ticks;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [CUBE_W:0]    trial;
    logic [CUBE_W+1:0]  diff;
    logic               qbit;
    logic [CUBE_W-1:0]  rem_iter;
    logic [NUM_W-1:0]   num;
    logic               in_div;

    // Operand preparation at start.
    always_comb begin
        if (req.rate < cfg.rate_floor) begin
            rate_clamped = cfg.rate_floor;
        end else if (req.rate > cfg.rate_ceiling) begin
            rate_clamped = cfg.rate_ceiling;
        end else begin
            rate_clamped = req.rate;
        end
    end

    assign s_val    = rate_clamped - cfg.rate_floor;
    assign d_val    = cfg.rate_ceiling - cfg.rate_floor;
    assign trivial  = (cfg.rate_ceiling <= cfg.rate_floor) || (s_val == '0);
    assign span     = {cfg.range_max[POS_W-1], cfg.range_max}
                    - {cfg.range_min[POS_W-1], cfg.range_min};
    assign span_pos = !span[POS_W] && (span != '0);
    assign ticks    = (cfg.full_span_ticks == '0) ? RATE_W'(1) : cfg.full_span_ticks;

    // One restoring division step, shared by both divisions.
    assign trial    = {rem_reg, qd_reg[POS_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, div_reg};
    assign qbit     = !diff[CUBE_W+1];
    assign rem_iter = qbit ? diff[CUBE_W-1:0] : trial[CUBE_W-1:0];

    // Numerator dl * s^3 from its two partial products.
    assign num = {{(NUM_W-MUL_P_W){1'b0}}, plo_reg} + {mul_reg, {MUL_B_W{1'b0}}};

    assign in_div = (state_reg == ACC_DIV_SPAN) || (state_reg == ACC_DIV_Q);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ACC_IDLE: begin
                if (req.start) begin
                    state_next = trivial ? ACC_DONE : ACC_DIV_SPAN;
                end
            end
            ACC_DIV_SPAN: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ACC_MUL_SS;
                end
            end
            ACC_MUL_SS:  state_next = ACC_MUL_C;
            ACC_MUL_C:   state_next = ACC_MUL_DD;
            ACC_MUL_DD:  state_next = ACC_MUL_D3;
            ACC_MUL_D3:  state_next = ACC_MUL_PLO;
            ACC_MUL_PLO: state_next = ACC_MUL_PHI;
            ACC_MUL_PHI: state_next = ACC_SUM;
            ACC_SUM:     state_next = ACC_DIV_Q;
            ACC_DIV_Q: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ACC_DONE;
                end
            end
            ACC_DONE:    state_next = ACC_IDLE;
            default:     state_next = ACC_IDLE;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ACC_MUL_SS: begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = MUL_B_W'(s_reg);
            end
            ACC_MUL_C: begin
                mul_a = mul_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(s_reg);
            end
            ACC_MUL_DD: begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = MUL_B_W'(d_reg);
            end
            ACC_MUL_D3: begin
                mul_a = mul_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(d_reg);
            end
            ACC_MUL_PLO: begin
                mul_a = dl_reg;
                mul_b = cube_reg[MUL_B_W-1:0];
            end
            ACC_MUL_PHI: begin
                mul_a = dl_reg;
                mul_b = cube_reg[CUBE_W-1:MUL_B_W];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rsp.done = (state_reg == ACC_DONE);
    assign rsp.step = qd_reg + 1'b1;

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        unique case (state_reg)
            ACC_IDLE: begin
                if (req.start) begin
                    s_reg   <= s_val;
                    d_reg   <= d_val;
                    rem_reg <= '0;
                    div_reg <= CUBE_W'(ticks);
                    qd_reg  <= (trivial || !span_pos) ? '0 : span[POS_W-1:0];
                end
            end
            ACC_DIV_SPAN, ACC_DIV_Q: begin
                rem_reg <= rem_iter;
                qd_reg  <= {qd_reg[POS_W-2:0], qbit};
            end
            ACC_MUL_SS: begin
                dl_reg <= (qd_reg == '0) ? POS_W'(1) : qd_reg;
            end
            ACC_MUL_DD: begin
                cube_reg <= mul_reg[CUBE_W-1:0];
            end
            ACC_MUL_PLO: begin
                div_reg <= mul_reg[CUBE_W-1:0];
            end
            ACC_MUL_PHI: begin
                plo_reg <= mul_reg;
            end
            ACC_SUM: begin
                rem_reg <= num[NUM_W-1:POS_W];
                qd_reg  <= num[POS_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ACC_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (in_div) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    `QDAD_ASSERT_IMPL(a_start_when_idle, aclk, aresetn, req.start, state_reg == ACC_IDLE, "accel started while busy")
    `QDAD_ASSERT_IMPL(a_rem_below_div, aclk, aresetn, in_div, rem_reg < div_reg, "divider remainder not below divisor")
    `QDAD_ASSERT_NEXT(a_done_single, aclk, aresetn, rsp.done, !rsp.done && state_reg == ACC_IDLE, "done not a single pulse")

endmodule

// ----- design/qdad_back.sv -----
// Execution side: applies commands to the positions and holds the result register.
module qdad_back
    import qdad_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  cmd_t                    cmd,
    input  logic                    cmd_empty,
    output logic                    cmd_pop,
    output acc_req_t                acc_req,
    input  acc_rsp_t                acc_rsp,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_position,
    output logic                    m_detent_reached
);

`include "quadrature_detent_accel_decoder_defines.svh"

    bk_state_t state_reg;
    bk_state_t state_next;

    logic [POS_W-1:0] fine_reg;
    logic [POS_W-1:0] fine_next;
    logic [POS_W-1:0] rep_reg;
    logic [POS_W-1:0] rep_next;
    cmd_t             cur_reg;
    logic [POS_W-1:0] step_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [POS_W-1:0] m_pos_reg;
    logic             m_hit_reg;

    logic                    slot_free;
    logic                    needs_accel;
    logic                    exec_now;
    logic                    apply_now;
    logic                    commit;
    logic                    hit_next;
    cmd_t                    op;
    logic [1:0]              sh;
    logic [POS_W-1:0]        keep;
    logic [POS_W-1:0]        np;
    logic [POS_W-1:0]        fine_moved;
    logic signed [POS_W-1:0] fine_moved_s;
    logic [POS_W-1:0]        fine_asr;

    assign slot_free   = !m_valid_reg || m_ready;
    assign needs_accel = (cmd.kind == CMD_MOVE) && (cmd.dir != DIR_NONE);
    assign sh          = detent_shift(cfg.detent_mode);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!cmd_empty && slot_free && needs_accel) begin
                    state_next = BK_ACCEL;
                end
            end
            BK_ACCEL: begin
                if (acc_rsp.done) begin
                    state_next = BK_APPLY;
                end
            end
            BK_APPLY: begin
                if (slot_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop       = (state_reg == BK_IDLE) && !cmd_empty && slot_free;
        acc_req.start = cmd_pop && needs_accel;
        acc_req.rate  = cmd.rate;
        exec_now      = cmd_pop && !needs_accel;
        apply_now     = (state_reg == BK_APPLY) && slot_free;
        commit        = exec_now || apply_now;
    end

    // Position update; a command without acceleration runs straight from the queue.
    assign op           = (state_reg == BK_APPLY) ? cur_reg : cmd;
    assign np           = op.new_position;
    assign keep         = ~({POS_W{1'b1}} << sh);
    assign fine_moved_s = fine_moved;
    assign fine_asr     = fine_moved_s >>> sh;

    always_comb begin
        unique case (op.dir)
            DIR_UP:   fine_moved = fine_reg + step_reg;
            DIR_DOWN: fine_moved = fine_reg - step_reg;
            default:  fine_moved = fine_reg;
        endcase
    end

    always_comb begin
        fine_next = fine_reg;
        rep_next  = rep_reg;
        hit_next  = 1'b0;
        unique case (op.kind)
            CMD_LOAD: begin
                fine_next = (np << sh) | (fine_reg & keep);
                rep_next  = np;
            end
            CMD_MOVE: begin
                fine_next = fine_moved;
                hit_next  = op.hit;
                if (op.hit) begin
                    rep_next = fine_asr;
                end
            end
            default: begin
                fine_next = fine_reg;
            end
        endcase
    end

    always_comb begin
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_req.start) begin
            cur_reg <= cmd;
        end
        if (acc_rsp.done) begin
            step_reg <= acc_rsp.step;
        end
        if (commit) begin
            m_pos_reg <= rep_next;
            m_hit_reg <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            fine_reg    <= '0;
            rep_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                fine_reg <= fine_next;
                rep_reg  <= rep_next;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_position       = m_pos_reg;
    assign m_detent_reached = m_hit_reg;

    `QDAD_ASSERT_IMPL(a_done_in_accel, aclk, aresetn, acc_rsp.done, state_reg == BK_ACCEL, "step arrived while not waiting")
    `QDAD_ASSERT_NEXT(a_commit_shows, aclk, aresetn, commit, m_valid_reg, "committed result not presented")
    `QDAD_ASSERT_NEXT(a_apply_holds, aclk, aresetn, state_reg == BK_APPLY && !slot_free, state_reg == BK_APPLY && $stable(fine_reg), "blocked apply changed state")

endmodule

// ----- design/quadrature_detent_accel_decoder.sv -----
// Quadrature decoder with detent reporting and cubic acceleration: top level.
// A load, an unchanged sample or a change without direction passes the command queue and
// then the result register; a counted change also waits on the shared step unit, with its
// two 32-step divisions and six multiplies, or skips them when the step is plainly one.
// One item per cycle unless m_ready stalls; a counted change holds the queue until applied.
// Reset (aresetn low, synchronous) clears pins and positions and loads register defaults.
module quadrature_detent_accel_decoder
    import qdad_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_addr,
    input  logic [POS_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_func,
    input  logic                    s_pin_a,
    input  logic                    s_pin_b,
    input  logic [RATE_W-1:0]       s_detent_rate,
    input  logic signed [POS_W-1:0] s_new_position,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_position,
    output logic                    m_detent_reached
);

    cfg_t     cfg_reg;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    cmd_t     q_wdata;
    cmd_t     q_rdata;
    acc_req_t acc_req;
    acc_rsp_t acc_rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.detent_mode     <= 3'd0;
            cfg_reg.range_min       <= '0;
            cfg_reg.range_max       <= POS_W'(1000);
            cfg_reg.rate_floor      <= RATE_W'(5);
            cfg_reg.rate_ceiling    <= RATE_W'(40);
            cfg_reg.full_span_ticks <= RATE_W'(100);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DETENT_MODE: begin
                    // Codes above the last encoder type are ignored.
                    if (cfg_wr_data[2:0] <= ENC_TYPE_MAX) begin
                        cfg_reg.detent_mode <= cfg_wr_data[2:0];
                    end
                end
                REG_RANGE_MIN:       cfg_reg.range_min       <= cfg_wr_data;
                REG_RANGE_MAX:       cfg_reg.range_max       <= cfg_wr_data;
                REG_RATE_FLOOR:      cfg_reg.rate_floor      <= cfg_wr_data[RATE_W-1:0];
                REG_RATE_CEILING:    cfg_reg.rate_ceiling    <= cfg_wr_data[RATE_W-1:0];
                REG_FULL_SPAN_TICKS: cfg_reg.full_span_ticks <= cfg_wr_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    qdad_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_pin_a        (s_pin_a),
        .s_pin_b        (s_pin_b),
        .s_detent_rate  (s_detent_rate),
        .s_new_position (s_new_position),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    qdad_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    qdad_accel u_accel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .req     (acc_req),
        .rsp     (acc_rsp)
    );

    qdad_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .cmd              (q_rdata),
        .cmd_empty        (q_empty),
        .cmd_pop          (q_pop),
        .acc_req          (acc_req),
        .acc_rsp          (acc_rsp),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position       (m_position),
        .m_detent_reached (m_detent_reached)
    );

endmodule
